### hw/rtl/look_at_view_matrix_unit_macros.svh
// Assertion macros used by the look-at view matrix back end.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef LOOK_AT_VIEW_MATRIX_UNIT_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LAVM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define LAVM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lavm_pkg.sv
// Package of the look-at view matrix unit: payload types, row codes, FSM states.
// No dependencies.
`default_nettype none

package lavm_pkg;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] focus_x;
        logic signed [31:0] focus_y;
        logic signed [31:0] focus_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } cam_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               degenerate;
        logic               last_row;
    } row_t;

    // Job handed from front to back: eye, up and focus minus eye.
    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
        logic signed [32:0] dir_x;
        logic signed [32:0] dir_y;
        logic signed [32:0] dir_z;
    } lavm_job_t;

    localparam logic [1:0] ROW_W = 2'd0;
    localparam logic [1:0] ROW_V = 2'd1;
    localparam logic [1:0] ROW_N = 2'd2;

    typedef enum logic [3:0] {
        B_IDLE,
        B_NORM_N,
        B_DOT_MUL,
        B_DOT_SUM,
        B_PROJ_MUL,
        B_PROJ_SUB,
        B_NORM_V,
        B_CROSS_A,
        B_CROSS_B,
        B_CROSS_SUB,
        B_NORM_W,
        B_ROW_MUL,
        B_ROW_OUT
    } lavm_back_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SCALE,
        N_SQ,
        N_SUM,
        N_SQRT,
        N_DIVI,
        N_DIV,
        N_DONE
    } lavm_norm_state_t;

endpackage

`default_nettype wire

### hw/rtl/lavm_fifo.sv
// Small register queue used between front and back and on the result side.
// No package dependencies.
`default_nettype none

module lavm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lavm_front.sv
// Front end: accepts camera items and forms focus minus eye for the back end.
// Depends on lavm_pkg.
`default_nettype none

module lavm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lavm_pkg::cam_t     cam,
    input  logic               job_full,
    output logic               job_push,
    output lavm_pkg::lavm_job_t job
);
    import lavm_pkg::*;

    logic      valid_reg, valid_next;
    lavm_job_t job_reg;
    logic      take;

    assign job_push = valid_reg;
    assign full     = valid_reg && job_full;
    assign take     = push && !full;
    assign job      = job_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !job_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Form the view direction at full width on entry.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg.eye_x <= cam.eye_x;
            job_reg.eye_y <= cam.eye_y;
            job_reg.eye_z <= cam.eye_z;
            job_reg.up_x  <= cam.up_x;
            job_reg.up_y  <= cam.up_y;
            job_reg.up_z  <= cam.up_z;
            job_reg.dir_x <= 33'(cam.focus_x) - 33'(cam.eye_x);
            job_reg.dir_y <= 33'(cam.focus_y) - 33'(cam.eye_y);
            job_reg.dir_z <= 33'(cam.focus_z) - 33'(cam.eye_z);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lavm_norm.sv
// Iterative 3-vector normalizer: scale, sum of squares, bitwise square root,
// three restoring dividers in lanes. Depends on lavm_pkg.
`default_nettype none

module lavm_norm #(
    parameter int FRAC_BITS = 16,
    parameter int VW        = 35
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [VW-1:0]        vec [3],
    output logic                        done,
    output logic                        ok,
    output logic signed [FRAC_BITS+1:0] res_vec [3]
);
    import lavm_pkg::*;

    localparam int NW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int RW = 31 + FRAC_BITS;
    localparam int JW = $clog2(FRAC_BITS + 1);

    lavm_norm_state_t state_reg, state_next;

    logic [VW-1:0] m_reg [3];
    logic          neg_reg [3];
    logic [VW-1:0] big_reg;
    logic [59:0]   sq_reg [3];
    logic [61:0]   x_reg, res_reg;
    logic [4:0]    k_reg;
    logic [RW-1:0] num_reg [3];
    logic [RW-1:0] dsh_reg;
    logic [QW-1:0] q_reg [3];
    logic [JW-1:0] j_reg;
    logic          ok_reg;

    logic [VW-1:0] ld_mag [3];
    logic [VW-1:0] ld_big;
    logic          big_hi, big_lo, big_zero;
    logic [61:0]   sq_bit, trial;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ld_mag[i] = vec[i][VW-1] ? (~vec[i] + 1'b1) : vec[i];
        end
        ld_big = ld_mag[0];
        if (ld_mag[1] > ld_big)
        begin
            ld_big = ld_mag[1];
        end
        if (ld_mag[2] > ld_big)
        begin
            ld_big = ld_mag[2];
        end
    end

    assign big_hi   = |big_reg[VW-1:30];
    assign big_lo   = !big_hi && !big_reg[29];
    assign big_zero = (big_reg == '0);
    assign sq_bit   = 62'(1) << {k_reg, 1'b0};
    assign trial    = res_reg + sq_bit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:  if (start) state_next = N_SCALE;
            N_SCALE:
            begin
                if (big_zero)
                begin
                    state_next = N_DONE;
                end
                else if (!big_hi && !big_lo)
                begin
                    state_next = N_SQ;
                end
            end
            N_SQ:    state_next = N_SUM;
            N_SUM:   state_next = N_SQRT;
            N_SQRT:  if (k_reg == '0) state_next = N_DIVI;
            N_DIVI:  state_next = N_DIV;
            N_DIV:   if (j_reg == '0) state_next = N_DONE;
            N_DONE:  state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == N_DONE);
    end

    assign ok = ok_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res_vec[i] = neg_reg[i] ? -$signed({1'b0, q_reg[i]})
                                    : $signed({1'b0, q_reg[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i]   <= ld_mag[i];
                        neg_reg[i] <= vec[i][VW-1];
                    end
                    big_reg <= ld_big;
                    ok_reg  <= 1'b1;
                end
            end
            N_SCALE:
            begin
                // Shift all three together until the largest sits in [2^29, 2^30).
                if (big_zero)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        q_reg[i] <= '0;
                    end
                    ok_reg <= 1'b0;
                end
                else if (big_hi)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                    big_reg <= big_reg >> 1;
                end
                else if (big_lo)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                    big_reg <= big_reg << 1;
                end
            end
            N_SQ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= m_reg[i][29:0] * m_reg[i][29:0];
                end
            end
            N_SUM:
            begin
                x_reg   <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
                res_reg <= '0;
                k_reg   <= 5'd30;
            end
            N_SQRT:
            begin
                if (x_reg >= trial)
                begin
                    x_reg   <= x_reg - trial;
                    res_reg <= (res_reg >> 1) + sq_bit;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                k_reg <= k_reg - 1'b1;
            end
            N_DIVI:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    num_reg[i] <= RW'(m_reg[i][29:0]) << FRAC_BITS;
                    q_reg[i]   <= '0;
                end
                dsh_reg <= RW'(res_reg[30:0]) << FRAC_BITS;
                j_reg   <= JW'(FRAC_BITS);
            end
            N_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (num_reg[i] >= dsh_reg)
                    begin
                        num_reg[i] <= num_reg[i] - dsh_reg;
                        q_reg[i]   <= {q_reg[i][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        q_reg[i] <= {q_reg[i][QW-2:0], 1'b0};
                    end
                end
                dsh_reg <= dsh_reg >> 1;
                j_reg   <= j_reg - 1'b1;
            end
            N_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/lavm_back.sv
// Back end: sequences the three normalizations, projection, cross product and
// row translation over three shared multiplier lanes. Depends on lavm_pkg, lavm_norm.
`default_nettype none
`include "look_at_view_matrix_unit_macros.svh"

module lavm_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    output logic                job_pop,
    input  lavm_pkg::lavm_job_t job,
    input  logic                out_full,
    output logic                out_push,
    output lavm_pkg::row_t      out_row
);
    import lavm_pkg::*;

    localparam int NW = FRAC_BITS + 2;
    localparam int AW = 36;
    localparam int PW = AW + NW;
    localparam int SW = PW + 2;
    localparam int VW = (2 * FRAC_BITS + 3 > 35) ? 2 * FRAC_BITS + 3 : 35;
    localparam logic signed [SW-1:0] MAXV = SW'(32'sh7fffffff);
    localparam logic signed [SW-1:0] MINV = ~MAXV;

    lavm_back_state_t state_reg, state_next;

    logic signed [31:0]   eye_reg [3];
    logic signed [31:0]   up_reg [3];
    logic signed [NW-1:0] n_reg [3];
    logic signed [NW-1:0] v_reg [3];
    logic signed [NW-1:0] w_reg [3];
    logic signed [AW-1:0] d_reg;
    logic signed [PW-1:0] prod_reg [3];
    logic signed [PW-1:0] hold_reg [3];
    logic [1:0]           r_reg;
    logic                 ok_reg;

    logic signed [AW-1:0] lane_a [3];
    logic signed [NW-1:0] lane_b [3];
    logic signed [NW-1:0] row_sel [3];
    logic signed [SW-1:0] sum_p, tr;
    logic signed [VW-1:0] norm_vec [3];
    logic signed [NW-1:0] norm_res [3];
    logic                 norm_start, norm_done, norm_ok;
    logic                 norm_wait;
    logic signed [31:0]   col3_sat;

    function automatic logic signed [SW-1:0] shr_tz(input logic signed [SW-1:0] x);
        logic [SW-1:0] m;
        logic [SW-1:0] s;
        m = x[SW-1] ? SW'(-x) : SW'(x);
        s = m >> FRAC_BITS;
        return x[SW-1] ? -$signed(s) : $signed(s);
    endfunction

    lavm_norm #(
        .FRAC_BITS(FRAC_BITS),
        .VW       (VW)
    ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .vec    (norm_vec),
        .done   (norm_done),
        .ok     (norm_ok),
        .res_vec(norm_res)
    );

    // Row vector for the translation pass.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unique case (r_reg)
                ROW_W:   row_sel[i] = w_reg[i];
                ROW_V:   row_sel[i] = v_reg[i];
                default: row_sel[i] = -n_reg[i];
            endcase
        end
    end

    // Multiplier lane operands per step.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lane_a[i] = '0;
            lane_b[i] = '0;
        end
        unique case (state_reg)
            B_DOT_MUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lane_a[i] = AW'(up_reg[i]);
                    lane_b[i] = n_reg[i];
                end
            end
            B_PROJ_MUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lane_a[i] = d_reg;
                    lane_b[i] = n_reg[i];
                end
            end
            B_CROSS_A:
            begin
                lane_a[0] = AW'(n_reg[1]); lane_b[0] = v_reg[2];
                lane_a[1] = AW'(n_reg[2]); lane_b[1] = v_reg[0];
                lane_a[2] = AW'(n_reg[0]); lane_b[2] = v_reg[1];
            end
            B_CROSS_B:
            begin
                lane_a[0] = AW'(n_reg[2]); lane_b[0] = v_reg[1];
                lane_a[1] = AW'(n_reg[0]); lane_b[1] = v_reg[2];
                lane_a[2] = AW'(n_reg[1]); lane_b[2] = v_reg[0];
            end
            // Keep the row products steady while a row waits for room.
            B_ROW_MUL, B_ROW_OUT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lane_a[i] = AW'(eye_reg[i]);
                    lane_b[i] = row_sel[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign sum_p = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);
    assign tr    = -shr_tz(sum_p);

    always_comb
    begin
        if (tr > MAXV)
        begin
            col3_sat = 32'sh7fffffff;
        end
        else if (tr < MINV)
        begin
            col3_sat = 32'sh80000000;
        end
        else
        begin
            col3_sat = 32'(tr);
        end
    end

    // Vector handed to the normalizer on each start.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            norm_vec[i] = '0;
        end
        unique case (state_reg)
            B_IDLE:
            begin
                norm_vec[0] = VW'(job.dir_x);
                norm_vec[1] = VW'(job.dir_y);
                norm_vec[2] = VW'(job.dir_z);
            end
            B_PROJ_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    norm_vec[i] = VW'(SW'(up_reg[i]) - shr_tz(SW'(prod_reg[i])));
                end
            end
            B_CROSS_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    norm_vec[i] = VW'(SW'(hold_reg[i]) - SW'(prod_reg[i]));
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:      if (!job_empty) state_next = B_NORM_N;
            B_NORM_N:    if (norm_done) state_next = B_DOT_MUL;
            B_DOT_MUL:   state_next = B_DOT_SUM;
            B_DOT_SUM:   state_next = B_PROJ_MUL;
            B_PROJ_MUL:  state_next = B_PROJ_SUB;
            B_PROJ_SUB:  state_next = B_NORM_V;
            B_NORM_V:    if (norm_done) state_next = B_CROSS_A;
            B_CROSS_A:   state_next = B_CROSS_B;
            B_CROSS_B:   state_next = B_CROSS_SUB;
            B_CROSS_SUB: state_next = B_NORM_W;
            B_NORM_W:    if (norm_done) state_next = B_ROW_MUL;
            B_ROW_MUL:   state_next = B_ROW_OUT;
            B_ROW_OUT:
            begin
                if (!out_full)
                begin
                    state_next = (r_reg == ROW_N) ? B_IDLE : B_ROW_MUL;
                end
            end
            default:     state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop    = (state_reg == B_IDLE) && !job_empty;
        norm_start = job_pop || (state_reg == B_PROJ_SUB) || (state_reg == B_CROSS_SUB);
        out_push   = (state_reg == B_ROW_OUT) && !out_full;
        norm_wait  = (state_reg == B_NORM_N) || (state_reg == B_NORM_V)
                     || (state_reg == B_NORM_W);
    end

    always_comb
    begin
        out_row.row_index  = r_reg;
        out_row.col0       = 32'(row_sel[0]);
        out_row.col1       = 32'(row_sel[1]);
        out_row.col2       = 32'(row_sel[2]);
        out_row.col3       = col3_sat;
        out_row.degenerate = !ok_reg;
        out_row.last_row   = (r_reg == ROW_N);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            r_reg     <= ROW_W;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_NORM_W)
            begin
                r_reg <= ROW_W;
            end
            else if (out_push && (r_reg != ROW_N))
            begin
                r_reg <= r_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i] <= lane_a[i] * lane_b[i];
        end
        if (job_pop)
        begin
            eye_reg[0] <= job.eye_x;
            eye_reg[1] <= job.eye_y;
            eye_reg[2] <= job.eye_z;
            up_reg[0]  <= job.up_x;
            up_reg[1]  <= job.up_y;
            up_reg[2]  <= job.up_z;
        end
        if (norm_done)
        begin
            unique case (state_reg)
                B_NORM_N:
                begin
                    n_reg  <= norm_res;
                    ok_reg <= norm_ok;
                end
                B_NORM_V:
                begin
                    v_reg  <= norm_res;
                    ok_reg <= ok_reg && norm_ok;
                end
                B_NORM_W:
                begin
                    w_reg  <= norm_res;
                    ok_reg <= ok_reg && norm_ok;
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == B_DOT_SUM)
        begin
            d_reg <= AW'(shr_tz(sum_p));
        end
        if (state_reg == B_CROSS_B)
        begin
            hold_reg <= prod_reg;
        end
    end

    `LAVM_ASSERT_IMP(a_done_when_waiting, norm_done, norm_wait, "normalizer done outside a wait")
    `LAVM_ASSERT_IMP(a_no_push_full, out_push, !out_full, "row pushed into full result queue")
    `LAVM_ASSERT_NXT(a_last_row_idle, out_push && (r_reg == ROW_N), state_reg == B_IDLE, "no idle")

endmodule

`default_nettype wire

### hw/rtl/look_at_view_matrix_unit.sv
// Top level of the look-at view matrix unit: front end, job queue, back end,
// result queue. Depends on lavm_pkg, lavm_front, lavm_fifo, lavm_back.
//
//   channel   direction  handshake            payload
//   camera    in         push / full          cam (eye, focus, up, Q16.16)
//   rows      out        pop / empty          row (index, col0..col3, flags)
//
// Each camera item yields three rows (w, v, minus n), oldest first.
// The back end's time per item is set by the square root loop and divider lanes
// of the normalizer and grows with the scaling shifts in the three normalizations.
// The front end takes a new item while the back end works; two jobs queue up.
// Reset clears all control state at once; no clearing pass is needed.
// A stalled row output holds in a four-entry result queue; the back end stalls
// only when that queue is full.
`default_nettype none

module look_at_view_matrix_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  lavm_pkg::cam_t cam,
    output logic           empty,
    input  logic           pop,
    output lavm_pkg::row_t row
);
    import lavm_pkg::*;

    localparam int JOB_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int JW = $bits(lavm_job_t);
    localparam int RW = $bits(row_t);

    lavm_job_t     front_job, back_job;
    logic [JW-1:0] job_dout;
    logic          job_push, job_full, job_pop, job_empty;
    row_t          back_row;
    logic [RW-1:0] row_dout;
    logic          out_push, out_full;

    // Accept and stage camera items, form the view direction.
    lavm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .cam     (cam),
        .job_full(job_full),
        .job_push(job_push),
        .job     (front_job)
    );

    // Decouple front and back.
    lavm_fifo #(
        .W    (JW),
        .DEPTH(JOB_DEPTH)
    ) u_job_q (
        .clk  (clk),
        .rst_n(rst_n),
        .wr_en(job_push),
        .din  (front_job),
        .full (job_full),
        .rd_en(job_pop),
        .dout (job_dout),
        .empty(job_empty)
    );

    assign back_job = lavm_job_t'(job_dout);

    // Carry out the normalizations and emit the three rows.
    lavm_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_empty(job_empty),
        .job_pop  (job_pop),
        .job      (back_job),
        .out_full (out_full),
        .out_push (out_push),
        .out_row  (back_row)
    );

    // Hold finished rows until the consumer transfers them.
    lavm_fifo #(
        .W    (RW),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .clk  (clk),
        .rst_n(rst_n),
        .wr_en(out_push),
        .din  (back_row),
        .full (out_full),
        .rd_en(pop),
        .dout (row_dout),
        .empty(empty)
    );

    assign row = row_t'(row_dout);

endmodule

`default_nettype wire
